FILE: sv/rgl_pkg.sv
// rgl_pkg: shared types and constants for the recursive gaussian line filter
// no dependencies; imported by recursive_gaussian_line_filter and its testbench
package rgl_pkg;

    // fixed field and datapath widths
    localparam int COEFF_W   = 18;   // signed coefficient registers
    localparam int REC_W     = 28;   // signed recursion value
    localparam int PIX_W     = 8;    // channel byte
    localparam int POS_W     = 11;   // position field of a result word
    localparam int NUM_LANES = 4;    // channel ports on the top level
    localparam int CFG_IDX_W = 3;    // config register index
    localparam int BYTE_MAX  = 255;

    typedef logic signed [COEFF_W-1:0] t_coeff;
    typedef logic signed [REC_W-1:0]   t_rec;
    typedef logic        [PIX_W-1:0]   t_pix;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_GAIN = 3'd0,
        CFG_BWD_GAIN = 3'd1,
        CFG_FB_COEFF = 3'd2,
        CFG_FWD_SEED = 3'd3,
        CFG_BWD_SEED = 3'd4
    } t_cfg_idx;

    // pass direction carried by each input word
    typedef enum logic {
        OP_FWD = 1'b0,
        OP_BWD = 1'b1
    } t_opcode;

    // coefficient reset values
    localparam t_coeff RST_FWD_GAIN = 18'sd30985;
    localparam t_coeff RST_BWD_GAIN = 18'sd12677;
    localparam t_coeff RST_FB_COEFF = -18'sd21876;
    localparam t_coeff RST_FWD_SEED = 18'sd46512;
    localparam t_coeff RST_BWD_SEED = 18'sd19038;

    // saturation bounds of the recursion value
    localparam t_rec REC_MAX = {1'b0, {(REC_W-1){1'b1}}};
    localparam t_rec REC_MIN = {1'b1, {(REC_W-1){1'b0}}};

endpackage

FILE: sv/recursive_gaussian_line_filter.sv
// recursive_gaussian_line_filter: one line pass of a first-order recursive blur
// depends on rgl_pkg (types, widths, register indexes, reset values)

// Takes one pixel word per clock on the input channel while o_in_ready is high. Forward
// words (opcode 0) run the forward recursion per channel and write the clipped byte into
// an internal line store of MAX_LINE words; they give no result. Backward words (opcode 1),
// fed in reverse order, run the backward recursion, add the stored byte and present one
// result word on the output through stage a, stage b and the output register. Sustained
// rate is one word per cycle in both directions while the output is not stalled; the clock
// is set by the per-channel recursion loop: one 28x18 multiply by the feedback
// coefficient, a subtract and a saturate between the recursion registers.
// The line store is one memory with a write port and a registered read port,
// not cleared after reset, so a backward pass must follow a forward pass over
// the same positions. Up to two words are held inside while a result waits. The user must
// write coefficients through the config port while the block is idle; it is not enforced.
module recursive_gaussian_line_filter
    import rgl_pkg::*;
#(
    parameter int MAX_LINE        = 2048,
    parameter int CHANNELS        = 4,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEFF_W-1:0]   i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic                 i_start_req,
    input  logic [PIX_W-1:0]     i_in_ch0,
    input  logic [PIX_W-1:0]     i_in_ch1,
    input  logic [PIX_W-1:0]     i_in_ch2,
    input  logic [PIX_W-1:0]     i_in_ch3,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_out_ch0,
    output logic [PIX_W-1:0]     o_out_ch1,
    output logic [PIX_W-1:0]     o_out_ch2,
    output logic [PIX_W-1:0]     o_out_ch3,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_overrun
);

    localparam int F      = COEFF_FRAC_BITS;
    localparam int AW     = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LPW    = $clog2(MAX_LINE + 1);
    localparam int WORD_W = PIX_W * CHANNELS;
    localparam int PROD_W = PIX_W + 1 + COEFF_W;   // byte times coefficient
    localparam int FB_W   = REC_W + COEFF_W;       // recursion times feedback
    localparam int DIFF_W = FB_W + 1;
    localparam int SUM_W  = ((PIX_W + F > REC_W) ? (PIX_W + F) : REC_W) + 2;

    // clip a recursion value to a byte: negatives and fractions give 0
    function automatic t_pix f_rec_byte(input t_rec v);
        logic [REC_W-1:0] q;
        q = REC_W'($unsigned(v) >> F);
        if (v[REC_W-1])
            return '0;
        else if (q > REC_W'(BYTE_MAX))
            return PIX_W'(BYTE_MAX);
        else
            return q[PIX_W-1:0];
    endfunction

    // same clip for the stored byte plus backward recursion
    function automatic t_pix f_sum_byte(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] q;
        q = SUM_W'($unsigned(v) >> F);
        if (v[SUM_W-1])
            return '0;
        else if (q > SUM_W'(BYTE_MAX))
            return PIX_W'(BYTE_MAX);
        else
            return q[PIX_W-1:0];
    endfunction

    // coefficient registers
    t_coeff r_fwd_gain, r_bwd_gain, r_fb_coeff, r_fwd_seed, r_bwd_seed;

    // line control state, tracked at acceptance
    logic [LPW-1:0] r_lp, n_lp;
    logic           r_ov, n_ov;

    // stage a: accepted word with its input products
    logic                     r_a_valid;
    logic                     r_a_op;
    logic                     r_a_start;
    logic signed [PROD_W-1:0] r_a_gp [CHANNELS];
    logic signed [PROD_W-1:0] r_a_sp [CHANNELS];
    logic [AW-1:0]            r_a_addr;
    logic                     r_a_wr;
    logic                     r_a_rdv;
    logic [AW-1:0]            r_a_pos;
    logic                     r_a_ov;
    logic [WORD_W-1:0]        r_rd;
    logic                     r_byp;
    logic [WORD_W-1:0]        r_byp_data;

    // stage b: backward recursion result with stored bytes
    logic              r_b_valid;
    t_rec              r_b_rec    [CHANNELS];
    t_pix              r_b_stored [CHANNELS];
    logic [AW-1:0]     r_b_pos;
    logic              r_b_ov;

    // output register
    logic              r_o_valid;
    t_pix              r_o_byte [CHANNELS];
    logic [AW-1:0]     r_o_pos;
    logic              r_o_ov;

    // recursion state per channel
    t_rec              r_rec [CHANNELS];
    t_rec              n_rec [CHANNELS];

    // line store
    logic [WORD_W-1:0] mem [MAX_LINE];

    logic              in_acc, a_go, b_go, b_free, c_free;
    logic              in_fwd, in_start;
    logic [LPW-1:0]    lp0;
    logic              ov0;
    logic              n_wr, n_rdv;
    logic [AW-1:0]     n_addr, n_pos;
    logic              n_byp;
    logic [WORD_W-1:0] wdata, stored_word;
    t_pix              in_pix [NUM_LANES];
    t_pix              w_out  [NUM_LANES];
    t_coeff            sel_gain, sel_seed;

    assign in_pix[0] = i_in_ch0;
    assign in_pix[1] = i_in_ch1;
    assign in_pix[2] = i_in_ch2;
    assign in_pix[3] = i_in_ch3;

    // handshake and stage flow
    assign c_free     = !r_o_valid || i_out_ready;
    assign b_go       = r_b_valid && c_free;
    assign b_free     = !r_b_valid || c_free;
    assign a_go       = r_a_valid && (b_free || r_a_op == OP_FWD);
    assign o_in_ready = !r_a_valid || a_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_fwd     = (t_opcode'(i_opcode) == OP_FWD);
    assign in_start   = i_start_req;
    assign sel_gain   = in_fwd ? r_fwd_gain : r_bwd_gain;
    assign sel_seed   = in_fwd ? r_fwd_seed : r_bwd_seed;

    // position and overrun bookkeeping for the incoming word
    always_comb begin
        lp0    = (in_fwd && in_start) ? '0 : r_lp;
        ov0    = (in_fwd && in_start) ? 1'b0 : r_ov;
        n_lp   = lp0;
        n_ov   = ov0;
        n_wr   = 1'b0;
        n_rdv  = 1'b0;
        n_addr = '0;
        n_pos  = '0;
        if (in_fwd) begin
            if (lp0 < LPW'(MAX_LINE)) begin
                n_wr   = 1'b1;
                n_addr = lp0[AW-1:0];
                n_lp   = lp0 + LPW'(1);
            end else begin
                n_ov = 1'b1;
            end
        end else begin
            if (r_lp != '0) begin
                n_lp   = r_lp - LPW'(1);
                n_rdv  = 1'b1;
                n_addr = n_lp[AW-1:0];
                n_pos  = n_lp[AW-1:0];
            end else begin
                n_ov = 1'b1;
            end
        end
    end

    // recursion step per channel; the seed product never exceeds 27 bits
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            t_rec                     cur;
            logic signed [FB_W-1:0]   fbp;
            logic signed [FB_W-1:0]   fbs;
            logic signed [DIFF_W-1:0] diff;
            cur  = r_a_start ? REC_W'(r_a_sp[c]) : r_rec[c];
            fbp  = cur * r_fb_coeff;
            fbs  = fbp >>> F;
            diff = DIFF_W'(r_a_gp[c]) - DIFF_W'(fbs);
            if (diff[DIFF_W-1] == 1'b0 && diff[DIFF_W-2:REC_W-1] != '0)
                n_rec[c] = REC_MAX;
            else if (diff[DIFF_W-1] == 1'b1 && diff[DIFF_W-2:REC_W-1] != '1)
                n_rec[c] = REC_MIN;
            else
                n_rec[c] = diff[REC_W-1:0];
            wdata[PIX_W*c +: PIX_W] = f_rec_byte(n_rec[c]);
        end
    end

    // a backward word reading the entry written at the same edge takes the new data
    assign n_byp       = a_go && r_a_wr && (r_a_addr == n_addr);
    assign stored_word = !r_a_rdv ? '0 : (r_byp ? r_byp_data : r_rd);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_gain <= RST_FWD_GAIN;
            r_bwd_gain <= RST_BWD_GAIN;
            r_fb_coeff <= RST_FB_COEFF;
            r_fwd_seed <= RST_FWD_SEED;
            r_bwd_seed <= RST_BWD_SEED;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FWD_GAIN: r_fwd_gain <= i_cfg_data;
                CFG_BWD_GAIN: r_bwd_gain <= i_cfg_data;
                CFG_FB_COEFF: r_fb_coeff <= i_cfg_data;
                CFG_FWD_SEED: r_fwd_seed <= i_cfg_data;
                CFG_BWD_SEED: r_bwd_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp      <= '0;
            r_ov      <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_lp  <= n_lp;
                r_ov  <= n_ov;
                r_byp <= n_byp;
            end
            r_a_valid <= in_acc ? 1'b1 : (r_a_valid && !a_go);
            r_b_valid <= (a_go && r_a_op == OP_BWD) ? 1'b1 : (r_b_valid && !c_free);
            r_o_valid <= b_go ? 1'b1 : (r_o_valid && !i_out_ready);
        end
    end

    // recursion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) r_rec[c] <= '0;
        end else if (a_go) begin
            for (int c = 0; c < CHANNELS; c++) r_rec[c] <= n_rec[c];
        end
    end

    // stage a payload: input products and store read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op     <= i_opcode;
            r_a_start  <= in_start;
            r_a_addr   <= n_addr;
            r_a_wr     <= n_wr;
            r_a_rdv    <= n_rdv;
            r_a_pos    <= n_pos;
            r_a_ov     <= n_ov;
            r_byp_data <= wdata;
            for (int c = 0; c < CHANNELS; c++) begin
                r_a_gp[c] <= $signed({1'b0, in_pix[c]}) * sel_gain;
                r_a_sp[c] <= $signed({1'b0, in_pix[c]}) * sel_seed;
            end
        end
    end

    // line store ports
    always_ff @(posedge i_clk) begin
        if (a_go && r_a_wr)
            mem[r_a_addr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_rd <= mem[n_addr];
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (a_go && r_a_op == OP_BWD) begin
            r_b_pos <= r_a_pos;
            r_b_ov  <= r_a_ov;
            for (int c = 0; c < CHANNELS; c++) begin
                r_b_rec[c]    <= n_rec[c];
                r_b_stored[c] <= stored_word[PIX_W*c +: PIX_W];
            end
        end
    end

    // output register: stored byte plus backward recursion, clipped
    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_o_pos <= r_b_pos;
            r_o_ov  <= r_b_ov;
            for (int c = 0; c < CHANNELS; c++) begin
                r_o_byte[c] <= f_sum_byte(
                    $signed({{(SUM_W-PIX_W-F){1'b0}}, r_b_stored[c], {F{1'b0}}})
                    + SUM_W'(r_b_rec[c]));
            end
        end
    end

    // output lanes, unused channels read zero
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_out
        if (g < CHANNELS) begin : g_used
            assign w_out[g] = r_o_byte[g];
        end else begin : g_unused
            assign w_out[g] = '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_ch0   = w_out[0];
    assign o_out_ch1   = w_out[1];
    assign o_out_ch2   = w_out[2];
    assign o_out_ch3   = w_out[3];
    assign o_position  = POS_W'(r_o_pos);
    assign o_overrun   = r_o_ov;

    // line position never runs past the store depth
    a_lp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp <= LPW'(MAX_LINE))
        else $error("line position beyond store depth");

    // a forward start restarts the line at the first entry
    a_fwd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_fwd && in_start |=> r_lp == LPW'(1) && !r_ov)
        else $error("forward start did not restart the line");

    // a backward word on an empty line flags overrun
    a_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !in_fwd && r_lp == '0 |=> r_ov && r_lp == '0)
        else $error("backward underrun not flagged");

    // a forward word past the end of the store flags overrun
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_fwd && !in_start && r_lp == LPW'(MAX_LINE) |=> r_ov)
        else $error("forward overrun not flagged");

    // a finished backward word is held while the output register is blocked
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_o_valid && !i_out_ready |=> r_b_valid)
        else $error("stage b word lost under output stall");

endmodule

FILE: tb/tb_recursive_gaussian_line_filter.sv
`timescale 1ns / 1ps
// tb_recursive_gaussian_line_filter: self-checking testbench for the line filter
// depends on rgl_pkg and recursive_gaussian_line_filter; predicts and checks each result word
module tb_recursive_gaussian_line_filter
    import rgl_pkg::*;
;

    localparam int LINE_DEPTH   = 2048;
    localparam int FRAC_BITS    = 16;
    localparam int RAND_WORDS   = 1700;
    localparam int CFG_EVERY    = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;

    localparam t_coeff COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam t_coeff COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

    typedef logic [NUM_LANES-1:0][PIX_W-1:0] t_lanes;

    typedef struct packed {
        t_opcode op;
        logic    start;
        t_lanes  ch;
    } t_pixel_word;

    typedef struct packed {
        t_lanes           ch;
        logic [POS_W-1:0] pos;
        logic             ovr;
    } t_blur_word;

    typedef enum int {
        SEQ_PAIR,
        SEQ_UNDERRUN,
        SEQ_NO_START,
        SEQ_SHORT_BWD,
        SEQ_NOISE
    } t_seq_kind;

    // block ports
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        cfg_we   = 1'b0;
    t_cfg_idx    cfg_idx  = CFG_FWD_GAIN;
    t_coeff      cfg_data = '0;
    logic        in_valid = 1'b0;
    t_pixel_word in_word  = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_pix        out_ch0, out_ch1, out_ch2, out_ch3;
    logic [POS_W-1:0] out_pos;
    logic        out_ovr;

    // predictor state: coefficients, line store, recursion, position and overrun
    t_coeff fwd_gain = RST_FWD_GAIN;
    t_coeff bwd_gain = RST_BWD_GAIN;
    t_coeff fb_coeff = RST_FB_COEFF;
    t_coeff fwd_seed = RST_FWD_SEED;
    t_coeff bwd_seed = RST_BWD_SEED;
    t_lanes line_store [LINE_DEPTH];
    longint rec_val [NUM_LANES] = '{default: 0};
    int     line_pos = 0;
    bit     line_ovr = 1'b0;

    // stimulus and expectation stores
    t_pixel_word pixel_q [$];
    t_blur_word  blur_q [$];
    int          queued_words = 0;
    int          errors = 0;
    bit          burst = 1'b0;
    bit          hold_req = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          quiet_cycles = 0;
    t_blur_word  got, want;

    recursive_gaussian_line_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (in_word.op),
        .i_start_req (in_word.start),
        .i_in_ch0    (in_word.ch[0]),
        .i_in_ch1    (in_word.ch[1]),
        .i_in_ch2    (in_word.ch[2]),
        .i_in_ch3    (in_word.ch[3]),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_ch0   (out_ch0),
        .o_out_ch1   (out_ch1),
        .o_out_ch2   (out_ch2),
        .o_out_ch3   (out_ch3),
        .o_position  (out_pos),
        .o_overrun   (out_ovr)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // 28-bit saturation of the recursion value
    function automatic longint clamp_rec(longint v);
        if (v > longint'(REC_MAX)) return longint'(REC_MAX);
        if (v < longint'(REC_MIN)) return longint'(REC_MIN);
        return v;
    endfunction

    // fixed-point value to byte: truncate, zero below one, clip at 255
    function automatic t_pix clip_byte(longint v);
        longint q;
        if (v <= 0) return '0;
        q = v >>> FRAC_BITS;
        return (q > BYTE_MAX) ? t_pix'(BYTE_MAX) : t_pix'(q);
    endfunction

    // one recursion step on one channel, seeded on the first pixel of a pass
    function automatic void lane_step(int ch, longint pix, t_coeff gain, t_coeff seed, bit start);
        if (start) rec_val[ch] = clamp_rec(pix * longint'(seed));
        rec_val[ch] = clamp_rec(pix * longint'(gain)
                                - ((rec_val[ch] * longint'(fb_coeff)) >>> FRAC_BITS));
    endfunction

    // advance the line state by one accepted word, queue the result it causes
    function automatic void predict_word(t_pixel_word w);
        t_lanes     stored;
        t_blur_word res;
        stored = '0;
        res = '0;
        if (w.op == OP_FWD) begin
            if (w.start) begin
                line_pos = 0;
                line_ovr = 1'b0;
            end
            for (int ch = 0; ch < NUM_LANES; ch++) begin
                lane_step(ch, longint'(w.ch[ch]), fwd_gain, fwd_seed, w.start);
                stored[ch] = clip_byte(rec_val[ch]);
            end
            if (line_pos < LINE_DEPTH) begin
                line_store[line_pos] = stored;
                line_pos++;
            end else begin
                line_ovr = 1'b1;
            end
        end else begin
            // walking below position zero reads nothing and flags the line
            if (line_pos > 0) begin
                line_pos--;
                res.pos = POS_W'(line_pos);
                stored = line_store[line_pos];
            end else begin
                line_ovr = 1'b1;
            end
            for (int ch = 0; ch < NUM_LANES; ch++) begin
                lane_step(ch, longint'(w.ch[ch]), bwd_gain, bwd_seed, w.start);
                res.ch[ch] = clip_byte((longint'(stored[ch]) <<< FRAC_BITS) + rec_val[ch]);
            end
            res.ovr = line_ovr;
            blur_q.push_back(res);
        end
    endfunction

    task automatic log_error(string msg);
        $display("[%0t] error: %s", $time, msg);
        errors++;
    endtask

    // input driver: offers queued words, random gap after each accepted word unless burst
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_word(in_word);
                in_gap = burst ? 0 : $urandom_range(0, 15);
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    in_word  <= pixel_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each result word, random stall after each, long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got.ch  = {out_ch3, out_ch2, out_ch1, out_ch0};
                got.pos = out_pos;
                got.ovr = out_ovr;
                if (blur_q.size() == 0) begin
                    log_error($sformatf("result word at position %0d with nothing pending",
                                        got.pos));
                end else begin
                    want = blur_q.pop_front();
                    for (int ch = 0; ch < NUM_LANES; ch++) begin
                        if (got.ch[ch] !== want.ch[ch])
                            log_error($sformatf("out_ch%0d at position %0d: expected %0d got %0d",
                                                ch, want.pos, want.ch[ch], got.ch[ch]));
                    end
                    if (got.pos !== want.pos)
                        log_error($sformatf("position: expected %0d got %0d", want.pos, got.pos));
                    if (got.ovr !== want.ovr)
                        log_error($sformatf("overrun at position %0d: expected %0d got %0d",
                                            want.pos, want.ovr, got.ovr));
                end
                out_gap = burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_req) begin
                out_gap  = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted input or result word
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout with %0d words queued and %0d results pending",
                         $time, pixel_q.size(), blur_q.size());
                $display("recursive_gaussian_line_filter verification failed");
                $finish;
            end
        end
    end

    // pixel values lean on the extremes
    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return t_pix'(BYTE_MAX);
            default: return t_pix'($urandom_range(0, BYTE_MAX));
        endcase
    endfunction

    function automatic t_coeff rand_coeff();
        case ($urandom_range(0, 7))
            0:       return COEFF_MAX;
            1:       return COEFF_MIN;
            2:       return '0;
            3, 4:    return t_coeff'($urandom_range(0, (1 << COEFF_W) - 1));
            default: return t_coeff'(int'($urandom_range(0, 98304)) - 49152);
        endcase
    endfunction

    function automatic t_pixel_word make_word(t_opcode op, bit start,
                                              t_pix c0, t_pix c1, t_pix c2, t_pix c3);
        t_pixel_word w;
        w.op    = op;
        w.start = start;
        w.ch    = {c3, c2, c1, c0};
        return w;
    endfunction

    // queue a run of random words in one direction
    task automatic queue_run(t_opcode op, int n, bit with_start);
        for (int i = 0; i < n; i++) begin
            pixel_q.push_back(make_word(op, with_start && (i == 0),
                                        pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel()));
            queued_words++;
        end
    endtask

    task automatic push_word(t_pixel_word w);
        pixel_q.push_back(w);
        queued_words++;
    endtask

    // block idle: nothing queued, offered or pending, then let the pipe drain
    task automatic wait_idle();
        @(negedge i_clk);
        while (pixel_q.size() > 0 || in_valid || blur_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, t_coeff val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic load_coeffs(input t_coeff fg, bg, fb, fs, bs);
        wait_idle();
        cfg_write(CFG_FWD_GAIN, fg);
        cfg_write(CFG_BWD_GAIN, bg);
        cfg_write(CFG_FB_COEFF, fb);
        cfg_write(CFG_FWD_SEED, fs);
        cfg_write(CFG_BWD_SEED, bs);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        fwd_gain = fg;
        bwd_gain = bg;
        fb_coeff = fb;
        fwd_seed = fs;
        bwd_seed = bs;
    endtask

    // main sequence
    initial begin
        int        base;
        int        next_cfg;
        int        len;
        int        pick;
        t_seq_kind kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset coefficients
        // backward word on an empty line: underrun at position zero
        push_word(make_word(OP_BWD, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // short line with extreme pixels
        push_word(make_word(OP_FWD, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_word(make_word(OP_FWD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        push_word(make_word(OP_FWD, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55));
        push_word(make_word(OP_FWD, 1'b0, 8'h55, 8'hAA, 8'h0F, 8'hF0));
        push_word(make_word(OP_BWD, 1'b1, 8'hFF, 8'h00, 8'hAA, 8'h55));
        push_word(make_word(OP_BWD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        push_word(make_word(OP_BWD, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_word(make_word(OP_BWD, 1'b0, 8'h01, 8'h02, 8'h04, 8'h80));
        // one word past the start of the line, reseeded
        push_word(make_word(OP_BWD, 1'b1, 8'h80, 8'h7F, 8'hFE, 8'h01));
        // passes without start continue the recursion and position
        push_word(make_word(OP_FWD, 1'b0, 8'hC8, 8'h10, 8'h00, 8'hFF));
        push_word(make_word(OP_FWD, 1'b0, 8'h33, 8'hCC, 8'hFF, 8'h00));
        push_word(make_word(OP_BWD, 1'b0, 8'hFF, 8'h00, 8'h80, 8'h40));
        push_word(make_word(OP_BWD, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h20));
        push_word(make_word(OP_BWD, 1'b0, 8'hEE, 8'h11, 8'h22, 8'hDD));
        // a fresh start clears the overrun flag
        push_word(make_word(OP_FWD, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        push_word(make_word(OP_BWD, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));

        // forward line past the store depth, then read back from the top
        queue_run(OP_FWD, LINE_DEPTH + 3, 1'b1);
        queue_run(OP_BWD, 4, 1'b1);
        queue_run(OP_FWD, 1, 1'b0);
        queue_run(OP_BWD, 3, 1'b0);

        // coefficient extremes
        load_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
        queue_run(OP_FWD, 6, 1'b1);
        queue_run(OP_BWD, 7, 1'b1);
        load_coeffs(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN);
        queue_run(OP_FWD, 6, 1'b1);
        queue_run(OP_BWD, 7, 1'b1);
        load_coeffs(COEFF_MAX, COEFF_MIN, COEFF_MIN, COEFF_MAX, COEFF_MIN);
        queue_run(OP_FWD, 5, 1'b1);
        queue_run(OP_BWD, 5, 1'b1);
        load_coeffs('0, '0, '0, '0, '0);
        queue_run(OP_FWD, 4, 1'b1);
        queue_run(OP_BWD, 4, 1'b1);

        // back-pressure: receiver holds off while the sender keeps offering
        load_coeffs(RST_FWD_GAIN, RST_BWD_GAIN, RST_FB_COEFF, RST_FWD_SEED, RST_BWD_SEED);
        burst = 1'b1;
        hold_req = 1'b1;
        queue_run(OP_FWD, 12, 1'b1);
        queue_run(OP_BWD, 40, 1'b1);
        wait_idle();

        // random sequences, mostly well-formed lines with random content
        base = queued_words;
        next_cfg = queued_words + CFG_EVERY;
        while (queued_words - base < RAND_WORDS) begin
            while (pixel_q.size() > 0) @(posedge i_clk);
            if (queued_words >= next_cfg) begin
                load_coeffs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
                next_cfg = queued_words + CFG_EVERY;
            end
            burst = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 96))
                                              : int'($urandom_range(1, 16));
            pick = $urandom_range(0, 19);
            if (pick < 12)      kind = SEQ_PAIR;
            else if (pick < 14) kind = SEQ_UNDERRUN;
            else if (pick < 16) kind = SEQ_NO_START;
            else if (pick < 18) kind = SEQ_SHORT_BWD;
            else                kind = SEQ_NOISE;
            case (kind)
                SEQ_PAIR: begin
                    queue_run(OP_FWD, len, 1'b1);
                    queue_run(OP_BWD, len, 1'b1);
                end
                SEQ_UNDERRUN: begin
                    queue_run(OP_FWD, len, 1'b1);
                    queue_run(OP_BWD, len + int'($urandom_range(1, 3)), 1'b1);
                end
                SEQ_NO_START: begin
                    queue_run(OP_FWD, len, 1'b0);
                    queue_run(OP_BWD, len, 1'b0);
                end
                SEQ_SHORT_BWD: begin
                    queue_run(OP_FWD, len, 1'b1);
                    queue_run(OP_BWD, (len + 1) / 2, 1'b1);
                end
                default: begin
                    for (int i = 0; i < len; i++)
                        queue_run(t_opcode'($urandom_range(0, 1)), 1, 1'($urandom_range(0, 1)));
                end
            endcase
        end

        // drain and report
        wait_idle();
        if (errors == 0) begin
            $display("recursive_gaussian_line_filter verification clean");
        end else begin
            $display("recursive_gaussian_line_filter verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/rgl_pkg.sv
sv/recursive_gaussian_line_filter.sv
tb/tb_recursive_gaussian_line_filter.sv
